// ===== rtl/dns_query_to_fixed_answer_assert.svh =====
// Assertion macros shared by the RTL
`ifndef DNS_QUERY_TO_FIXED_ANSWER_ASSERT_SVH
`define DNS_QUERY_TO_FIXED_ANSWER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DQFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DQFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dqfa_pkg.sv =====
package dqfa_pkg;

  // One query byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_t;

  // One reply byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       malformed;
  } out_t;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_TAIL   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // Register indexes
  localparam logic REG_ANSWER_IP  = 1'b0;
  localparam logic REG_ANSWER_TTL = 1'b1;

  localparam logic [31:0] ANSWER_IP_RESET  = 32'hC0A8_0401;
  localparam logic [31:0] ANSWER_TTL_RESET = 32'd60;

  // Header rewrite values
  localparam logic [7:0] FLAGS_HI   = 8'h81;
  localparam logic [7:0] FLAGS_LO   = 8'h80;
  localparam logic [7:0] ANCOUNT_HI = 8'h00;
  localparam logic [7:0] ANCOUNT_LO = 8'h01;

  // Answer record constants
  localparam logic [7:0] PTR_HI   = 8'hC0;
  localparam logic [7:0] PTR_LO   = 8'h0C;
  localparam logic [7:0] RDLEN_LO = 8'h04;

  // Header is 12 bytes, type/class tail is 4
  localparam int unsigned HEADER_LEN = 12;
  localparam logic [2:0]  TAIL_LEN   = 3'd4;

endpackage

// ===== rtl/dns_query_to_fixed_answer.sv =====
// DNS query to fixed answer. Query bytes enter one per cycle on in_* while
// in_ready_o is high; each header/name/type-class byte leaves through a
// registered output stage (flags become 81 80, answer count 00 01, trailing
// bytes are dropped). After a well-formed final byte a 16-byte A record
// follows, driven from an answer byte counter through the same output
// register; input ready is held low while it goes out. A query that ends
// early or runs past MAX_PACKET bytes ends with one byte flagged malformed
// and no answer. answer_ip is at address 0, answer_ttl at 4 of the APB port.
`include "dns_query_to_fixed_answer_assert.svh"

module dns_query_to_fixed_answer
  import dqfa_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PosW = $clog2(MAX_PACKET + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET);
  localparam logic [PosW-1:0] HdrEnd = PosW'(HEADER_LEN - 1);

  // Configuration registers
  logic [31:0] ip_q, ttl_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q  <= ANSWER_IP_RESET;
      ttl_q <= ANSWER_TTL_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ANSWER_IP:  ip_q  <= pwdata;
        REG_ANSWER_TTL: ttl_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ANSWER_IP:  prdata = ip_q;
      REG_ANSWER_TTL: prdata = ttl_q;
      default:        prdata = '0;
    endcase
  end

  // Parser state
  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [2:0]      tail_q, tail_d;
  logic            ovf_q, ovf_d;

  // Output stage and answer counter
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic       ans_busy_q, ans_busy_d;
  logic [3:0] ans_idx_q, ans_idx_d;

  logic slot_free, in_fire;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = slot_free && !ans_busy_q;
  assign in_fire    = in_valid_i && in_ready_o;

  // Per-byte parse results
  logic [PosW-1:0] pos_n;
  phase_e          phase_n;
  logic [2:0]      tail_n;
  logic            ovf_n, emit, bad;
  logic [7:0]      ob;

  always_comb begin
    pos_n   = pos_q;
    phase_n = phase_q;
    tail_n  = tail_q;
    ovf_n   = ovf_q;
    emit    = 1'b0;
    ob      = in_data_i.in_byte;
    if (pos_q >= MaxPos) begin
      ovf_n = 1'b1;
    end else begin
      pos_n = pos_q + PosW'(1);
      case (phase_q)
        PH_HEADER: begin
          emit = 1'b1;
          if (pos_q == PosW'(2))      ob = FLAGS_HI;
          else if (pos_q == PosW'(3)) ob = FLAGS_LO;
          else if (pos_q == PosW'(6)) ob = ANCOUNT_HI;
          else if (pos_q == PosW'(7)) ob = ANCOUNT_LO;
          if (pos_q >= HdrEnd) phase_n = PH_NAME;
        end
        PH_NAME: begin
          emit = 1'b1;
          if (in_data_i.in_byte == 8'd0) begin
            phase_n = PH_TAIL;
            tail_n  = 3'd0;
          end
        end
        PH_TAIL: begin
          emit   = 1'b1;
          tail_n = tail_q + 3'd1;
          if (tail_n >= TAIL_LEN) phase_n = PH_DONE;
        end
        default: ;
      endcase
    end
    bad = in_data_i.last_in && (ovf_n || phase_n != PH_DONE);
  end

  // Answer record byte by index
  function automatic logic [7:0] ans_byte(logic [3:0] idx, logic [31:0] ttl,
                                          logic [31:0] ip);
    logic [7:0] b;
    case (idx)
      4'd0:    b = PTR_HI;
      4'd1:    b = PTR_LO;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h01;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = 8'h00;
      4'd11:   b = RDLEN_LO;
      4'd12:   b = ip[31:24];
      4'd13:   b = ip[23:16];
      4'd14:   b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  // Next state for parser, output stage and answer counter
  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    tail_d      = tail_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ans_busy_d  = ans_busy_q;
    ans_idx_d   = ans_idx_q;

    if (in_fire) begin
      if (in_data_i.last_in) begin
        pos_d   = '0;
        phase_d = PH_HEADER;
        tail_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        pos_d   = pos_n;
        phase_d = phase_n;
        tail_d  = tail_n;
        ovf_d   = ovf_n;
      end
      if (bad) begin
        out_valid_d = 1'b1;
        out_d       = '{out_byte: ob, last_out: 1'b1, malformed: 1'b1};
      end else if (emit) begin
        out_valid_d = 1'b1;
        out_d       = '{out_byte: ob, last_out: 1'b0, malformed: 1'b0};
      end
      if (in_data_i.last_in && !bad) begin
        ans_busy_d = 1'b1;
        ans_idx_d  = 4'd0;
      end
    end else if (ans_busy_q && slot_free) begin
      out_valid_d = 1'b1;
      out_d       = '{out_byte:  ans_byte(ans_idx_q, ttl_q, ip_q),
                      last_out:  (ans_idx_q == 4'd15),
                      malformed: 1'b0};
      ans_idx_d   = ans_idx_q + 4'd1;
      if (ans_idx_q == 4'd15) ans_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_HEADER;
      tail_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      ans_busy_q  <= 1'b0;
      ans_idx_q   <= '0;
    end else begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      tail_q      <= tail_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      ans_busy_q  <= ans_busy_d;
      ans_idx_q   <= ans_idx_d;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `DQFA_ASSERT_IMP(a_bad_is_last, clk_i, rst_ni,
    out_valid_o && out_data_o.malformed, out_data_o.last_out,
    "malformed byte without last_out")
  `DQFA_ASSERT_NXT(a_ans_last, clk_i, rst_ni,
    ans_busy_q && slot_free && !in_fire && ans_idx_q == 4'd15,
    out_valid_o && out_data_o.last_out && !ans_busy_q,
    "final answer byte not marked last")
  `DQFA_ASSERT_NXT(a_final_clears, clk_i, rst_ni,
    in_fire && in_data_i.last_in,
    pos_q == '0 && phase_q == PH_HEADER && !ovf_q,
    "parser state not cleared after final byte")

endmodule

// ===== test/dqfa_checker.sv =====
`timescale 1ns / 100ps

// Watches both byte channels and the register port of the DNS responder,
// predicts every reply byte and compares the accepted ones in order.
module dqfa_checker
  import dqfa_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,

  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,

  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,

  output int          errors_o,
  output int          pending_o
);

  // Header offsets that get rewritten, and the fixed record fields
  localparam int unsigned FLAGS_POS_HI   = 2;
  localparam int unsigned FLAGS_POS_LO   = 3;
  localparam int unsigned ANCOUNT_POS_HI = 6;
  localparam int unsigned ANCOUNT_POS_LO = 7;
  localparam logic [15:0] RR_TYPE_A      = 16'h0001;
  localparam logic [15:0] RR_CLASS_IN    = 16'h0001;
  localparam logic [7:0]  RDLEN_HI       = 8'h00;

  // Predictor copy of the registers and the parser
  logic [31:0] reply_ip;
  logic [31:0] reply_ttl;
  int unsigned query_pos;
  phase_e      query_phase;
  logic [2:0]  type_class_seen;
  logic        query_too_long;

  out_t reply_q[$];
  int   mismatches = 0;
  int   replies_due = 0;

  assign errors_o  = mismatches;
  assign pending_o = replies_due;

  function automatic logic [7:0] rewrite_header(input int unsigned pos, input logic [7:0] b);
    case (pos)
      FLAGS_POS_HI:   return FLAGS_HI;
      FLAGS_POS_LO:   return FLAGS_LO;
      ANCOUNT_POS_HI: return ANCOUNT_HI;
      ANCOUNT_POS_LO: return ANCOUNT_LO;
      default:        return b;
    endcase
  endfunction

  function automatic void add_reply(input logic [7:0] b, input logic last, input logic bad);
    out_t r;
    r.out_byte  = b;
    r.last_out  = last;
    r.malformed = bad;
    reply_q.push_back(r);
  endfunction

  function automatic void restart_query();
    query_pos       = 0;
    query_phase     = PH_HEADER;
    type_class_seen = '0;
    query_too_long  = 1'b0;
  endfunction

  // Works out the reply bytes caused by one query byte
  function automatic void predict_reply(input in_t item);
    logic [7:0]   ob;
    logic         emit;
    logic [127:0] answer;
    ob   = item.in_byte;
    emit = 1'b0;
    if (query_pos >= MAX_PACKET) begin
      query_too_long = 1'b1;
    end else begin
      case (query_phase)
        PH_HEADER: begin
          emit = 1'b1;
          ob   = rewrite_header(query_pos, item.in_byte);
          if (query_pos >= HEADER_LEN - 1) query_phase = PH_NAME;
        end
        PH_NAME: begin
          emit = 1'b1;
          if (item.in_byte == 8'h00) begin
            query_phase     = PH_TAIL;
            type_class_seen = '0;
          end
        end
        PH_TAIL: begin
          emit            = 1'b1;
          type_class_seen = type_class_seen + 3'd1;
          if (type_class_seen >= TAIL_LEN) query_phase = PH_DONE;
        end
        default: ;
      endcase
      query_pos = query_pos + 1;
    end

    if (!item.last_in) begin
      if (emit) add_reply(ob, 1'b0, 1'b0);
    end else if (query_too_long || query_phase != PH_DONE) begin
      // rejected query: one flagged byte, no answer
      add_reply(ob, 1'b1, 1'b1);
      restart_query();
    end else begin
      if (emit) add_reply(ob, 1'b0, 1'b0);
      answer = {PTR_HI, PTR_LO, RR_TYPE_A, RR_CLASS_IN, reply_ttl,
                RDLEN_HI, RDLEN_LO, reply_ip};
      for (int k = 15; k >= 0; k--) add_reply(answer[k*8 +: 8], k == 0, 1'b0);
      restart_query();
    end
  endfunction

  // Register writes, then the query side, then the reply side
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      reply_ip  = ANSWER_IP_RESET;
      reply_ttl = ANSWER_TTL_RESET;
      restart_query();
      reply_q.delete();
      replies_due = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[1:0] == 2'b00) begin
        case (paddr_i[2])
          REG_ANSWER_IP:  reply_ip  = pwdata_i;
          REG_ANSWER_TTL: reply_ttl = pwdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) predict_reply(in_data_i);

      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected reply byte %h last %b malformed %b", $time,
                   out_data_i.out_byte, out_data_i.last_out, out_data_i.malformed);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte ||
              out_data_i.last_out !== want.last_out ||
              out_data_i.malformed !== want.malformed) begin
            $display("%0t: reply mismatch: expected byte %h last %b malformed %b, got byte %h last %b malformed %b",
                     $time, want.out_byte, want.last_out, want.malformed,
                     out_data_i.out_byte, out_data_i.last_out, out_data_i.malformed);
            mismatches++;
          end
        end
      end
      replies_due = reply_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the DNS responder; checking is done in dqfa_checker.
module testbench
  import dqfa_pkg::*;
();

  localparam int unsigned MAX_PACKET = 512;
  localparam logic [2:0]  ADDR_ANSWER_IP  = 3'd0;
  localparam logic [2:0]  ADDR_ANSWER_TTL = 3'd4;
  localparam int          SETTLE_CYCLES   = 20;
  localparam int          BYTES_PER_PHASE = 70;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int check_errors;
  int replies_due;

  int in_gap_pct;
  int out_stall_pct;
  int sent_bytes;
  logic [7:0] query_bytes[$];

  dns_query_to_fixed_answer #(
    .MAX_PACKET (MAX_PACKET)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dqfa_checker #(
    .MAX_PACKET (MAX_PACKET)
  ) reply_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .errors_o    (check_errors),
    .pending_o   (replies_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reply side back-pressure
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("dns_query_to_fixed_answer test failed");
    $finish;
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off the query side until every reply byte is out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (replies_due != 0) @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_t item;
    item.in_byte = b;
    item.last_in = last;
    while ($urandom_range(99) < in_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sends the first len bytes of the built query, the last one marked final
  task automatic send_query(input int len);
    for (int i = 0; i < len; i++) send_byte(query_bytes[i], i == len - 1);
    sent_bytes += len;
  endtask

  function automatic void build_query(input int name_len, input int trail_len);
    query_bytes.delete();
    repeat (HEADER_LEN) query_bytes.push_back(8'($urandom_range(255)));
    repeat (name_len) query_bytes.push_back(8'($urandom_range(1, 255)));
    query_bytes.push_back(8'h00);
    repeat (TAIL_LEN) query_bytes.push_back(8'($urandom_range(255)));
    repeat (trail_len) query_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly well-formed queries, some cut short, some plain noise
  task automatic random_query();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      build_query($urandom_range(0, 12), $urandom_range(0, 4));
      send_query(query_bytes.size());
    end else if (pick < 80) begin
      build_query($urandom_range(0, 8), 0);
      send_query($urandom_range(1, query_bytes.size() - 1));
    end else if (pick < 90) begin
      query_bytes.delete();
      repeat ($urandom_range(1, 30)) query_bytes.push_back(8'($urandom_range(255)));
      send_query(query_bytes.size());
    end else begin
      build_query($urandom_range(0, 6), $urandom_range(5, 20));
      send_query(query_bytes.size());
    end
  endtask

  task automatic settle_and_configure(input logic [31:0] ip, input logic [31:0] ttl);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    apb_write(ADDR_ANSWER_IP, ip);
    apb_write(ADDR_ANSWER_TTL, ttl);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_gap_pct    = 11;
    out_stall_pct = 64;
    sent_bytes    = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Smallest complete query, all ones but its zero name terminator, ending on its last type/class byte
    build_query(0, 0);
    for (int i = 0; i < HEADER_LEN; i++) query_bytes[i] = 8'hFF;
    for (int i = HEADER_LEN + 1; i < query_bytes.size(); i++) query_bytes[i] = 8'hFF;
    send_query(query_bytes.size());
    // Query of a single zero byte
    query_bytes[0] = 8'h00;
    send_query(1);
    // Query ending on the first flags byte
    build_query(0, 0);
    send_query(3);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          settle_and_configure(32'h0000_0000, 32'hFFFF_FFFF);
          in_gap_pct    = 11;
          out_stall_pct = 64;
        end
        1: begin
          settle_and_configure($urandom, $urandom);
          in_gap_pct    = 64;
          out_stall_pct = 11;
        end
        default: begin
          settle_and_configure(32'hFFFF_FFFF, 32'h0000_0000);
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase

      sent_bytes = 0;
      while (sent_bytes < BYTES_PER_PHASE) begin
        random_query();
        if (phase == 1 && $urandom_range(99) < 20) wait_drained();
      end

      // One query near the size limit in each of the first two phases
      if (phase == 0) begin
        // runs past the limit: rejected
        build_query(3, MAX_PACKET + 3 - 20);
        send_query(query_bytes.size());
      end else if (phase == 1) begin
        // exactly at the limit: still answered
        build_query(3, MAX_PACKET - 20);
        send_query(query_bytes.size());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (check_errors == 0 && replies_due == 0) begin
      $display("dns_query_to_fixed_answer test passed");
    end else begin
      $display("dns_query_to_fixed_answer test failed");
    end
    $finish;
  end

endmodule
